>>> rtl/core/wips_pkg.sv
// Shared types, register indexes and operation codes of the wheel PI speed loop.
`timescale 1ns / 1ps

package wips_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int TARGET_W    = 24;
    localparam int ERROR_W     = 25;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_SPEED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INVERT_SPEED = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PWM_PERIOD   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I       = 3'd5;

    // Operation codes of an input word.
    localparam logic OP_SET_SPEED = 1'b0;
    localparam logic OP_TICK      = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [14:0] MAX_SPEED_RESET   = 15'd1000;
    localparam logic [15:0] SPEED_SCALE_RESET = 16'd256;
    localparam logic [15:0] PWM_PERIOD_RESET  = 16'd1200;
    localparam logic [15:0] GAIN_P_RESET      = 16'd120;
    localparam logic [15:0] GAIN_I_RESET      = 16'd3;

    typedef struct packed {
        logic [14:0] max_speed;
        logic [15:0] speed_scale_q8;
        logic        invert_speed;
        logic [15:0] pwm_period;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
    } cfg_t;

    typedef struct packed {
        logic                       direction;
        logic [TARGET_W-1:0]        target_counts;
        logic signed [ERROR_W-1:0]  last_error;
        logic [15:0]                drive;
    } loop_state_t;

    typedef struct packed {
        logic        operation;
        logic [15:0] speed;
        logic [15:0] encoder_count;
        logic        stop;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] compare_a;
        logic [15:0] compare_b;
        logic [15:0] drive_level;
    } res_word_t;

endpackage

>>> rtl/core/wips_step_calc.sv
// Single-pass datapath: speed command to target, and the incremental PI tick.
`timescale 1ns / 1ps

module wips_step_calc (
    input  wips_pkg::cfg_t        cfg,
    input  wips_pkg::loop_state_t state,
    input  wips_pkg::cmd_word_t   cmd,
    output wips_pkg::loop_state_t state_next,
    output wips_pkg::res_word_t   res
);

    // Set speed path.
    logic signed [16:0] speed_ext;
    logic signed [16:0] speed_dir;
    logic [16:0]        speed_mag;
    logic [14:0]        mag_lim;
    logic [31:0]        scaled;

    // Tick path.
    logic signed [16:0] count_ext;
    logic [16:0]        enc_abs;
    logic signed [24:0] err;
    logic signed [25:0] err_diff;
    logic signed [42:0] p_term;
    logic signed [41:0] i_term;
    logic signed [43:0] acc;
    logic [15:0]        drive_new;

    assign speed_ext = $signed({cmd.speed[15], cmd.speed});
    assign speed_dir = cfg.invert_speed ? -speed_ext : speed_ext;
    assign speed_mag = speed_dir[16] ? 17'(-speed_dir) : 17'(speed_dir);
    assign mag_lim   = (speed_mag > {2'b00, cfg.max_speed}) ? cfg.max_speed : speed_mag[14:0];
    // Rounded half up: add one half of the Q8.8 unit before dropping the fraction.
    assign scaled    = 32'(mag_lim) * 32'(cfg.speed_scale_q8) + 32'd128;

    assign count_ext = $signed({cmd.encoder_count[15], cmd.encoder_count});
    assign enc_abs   = count_ext[16] ? 17'(-count_ext) : 17'(count_ext);
    assign err       = $signed({1'b0, state.target_counts}) - $signed({8'b0, enc_abs});
    assign err_diff  = 26'(err) - 26'(state.last_error);
    assign p_term    = 43'($signed({1'b0, cfg.gain_p})) * 43'(err_diff);
    assign i_term    = 42'($signed({1'b0, cfg.gain_i})) * 42'(err);
    assign acc       = 44'(p_term) + 44'(i_term) + $signed({28'b0, state.drive});

    always_comb
    begin
        if (state.target_counts == '0)
            drive_new = '0;
        else if (acc > $signed({28'b0, cfg.pwm_period}))
            drive_new = cfg.pwm_period;
        else if (acc < 0)
            drive_new = '0;
        else
            drive_new = acc[15:0];
    end

    always_comb
    begin
        state_next = state;
        res        = '0;
        if (cmd.operation == wips_pkg::OP_SET_SPEED)
        begin
            state_next.direction     = ~speed_dir[16];
            state_next.target_counts = scaled[31:8];
        end
        else if (!cmd.stop)
        begin
            state_next.last_error = err;
            state_next.drive      = drive_new;
            res.drive_level       = drive_new;
            if (state.direction)
            begin
                res.compare_a = cfg.pwm_period;
                res.compare_b = cfg.pwm_period - drive_new;
            end
            else
            begin
                res.compare_a = cfg.pwm_period - drive_new;
                res.compare_b = cfg.pwm_period;
            end
        end
    end

endmodule

>>> rtl/core/wheel_incremental_pi_speed_loop.sv
// Top level of the incremental PI speed loop for one H-bridge wheel channel.
// A tick word is held in the input register until its result word is loaded out.
// Throughput: one input word per cycle while no held result stalls a tick word;
// set speed words give no result word. The loop state register is updated as a word
// advances, with a tick word in the same cycle as the result register is loaded.
// Reset clears configuration to its defaults and the loop state to zero at once.
`timescale 1ns / 1ps

module wheel_incremental_pi_speed_loop (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wips_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wips_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic                             operation,
    input  logic [15:0]                      speed,
    input  logic [15:0]                      encoder_count,
    input  logic                             stop,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [15:0]                      compare_a,
    output logic [15:0]                      compare_b,
    output logic [15:0]                      drive_level
);

    wips_pkg::cfg_t        cfg_reg;
    wips_pkg::loop_state_t state_reg;
    wips_pkg::loop_state_t state_next;
    wips_pkg::cmd_word_t   cmd_reg;
    wips_pkg::res_word_t   res_reg;
    wips_pkg::res_word_t   res_next;
    logic                  cmd_valid_reg;
    logic                  res_valid_reg;
    logic                  out_free;
    logic                  advance;
    logic                  load_out;
    logic                  cmd_take;

    wips_step_calc u_calc (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .cmd        (cmd_reg),
        .state_next (state_next),
        .res        (res_next)
    );

    // A set speed word never needs the result register, so it moves on regardless.
    assign out_free  = !res_valid_reg || !res_stall;
    assign advance   = cmd_valid_reg &&
                       (cmd_reg.operation == wips_pkg::OP_SET_SPEED || out_free);
    assign load_out  = advance && cmd_reg.operation == wips_pkg::OP_TICK;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    assign res_valid   = res_valid_reg;
    assign compare_a   = res_reg.compare_a;
    assign compare_b   = res_reg.compare_b;
    assign drive_level = res_reg.drive_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_speed      <= wips_pkg::MAX_SPEED_RESET;
            cfg_reg.speed_scale_q8 <= wips_pkg::SPEED_SCALE_RESET;
            cfg_reg.invert_speed   <= 1'b0;
            cfg_reg.pwm_period     <= wips_pkg::PWM_PERIOD_RESET;
            cfg_reg.gain_p         <= wips_pkg::GAIN_P_RESET;
            cfg_reg.gain_i         <= wips_pkg::GAIN_I_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wips_pkg::REG_MAX_SPEED:    cfg_reg.max_speed      <= cfg_data[14:0];
                wips_pkg::REG_SPEED_SCALE:  cfg_reg.speed_scale_q8 <= cfg_data;
                wips_pkg::REG_INVERT_SPEED: cfg_reg.invert_speed   <= cfg_data[0];
                wips_pkg::REG_PWM_PERIOD:   cfg_reg.pwm_period     <= cfg_data;
                wips_pkg::REG_GAIN_P:       cfg_reg.gain_p         <= cfg_data;
                wips_pkg::REG_GAIN_I:       cfg_reg.gain_i         <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cmd_take)
                cmd_valid_reg <= cmd_valid;
            else if (advance)
                cmd_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;

            if (load_out)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_valid)
        begin
            cmd_reg.operation     <= operation;
            cmd_reg.speed         <= speed;
            cmd_reg.encoder_count <= encoder_count;
            cmd_reg.stop          <= stop;
        end
        if (load_out)
            res_reg <= res_next;
    end

    // The input register only blocks new words while it holds one.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> cmd_valid_reg)
        else $error("input stalled with an empty input register");

    // A stopped tick yields an all-zero result word.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && cmd_reg.stop |=> res_valid_reg && res_reg == '0)
        else $error("stopped tick gave a nonzero result word");

    // A stopped tick leaves the loop state alone.
    a_stop_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && cmd_reg.stop |=> $stable(state_reg))
        else $error("stopped tick changed the loop state");

    // With a zero target a running tick clears the drive.
    a_zero_target_drive: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !cmd_reg.stop && state_reg.target_counts == '0
        |=> state_reg.drive == '0 && res_reg.drive_level == '0)
        else $error("drive not cleared with a zero target");

endmodule
